// ===== rtl/core/ffg_pkg.sv =====
// ffg_pkg: shared types and constants for the free gap finder
// holds region and control structs, status codes, config indexes and reset values
// no dependencies
package ffg_pkg;

	localparam int MAX_REGIONS_DEF = 32;

	localparam logic [31:0] CHIP_BYTES_RST = 32'd4194304;

	// configuration register indexes
	localparam logic [1:0] CFG_MIN_GAP    = 2'd0;
	localparam logic [1:0] CFG_BASE_ADDR  = 2'd1;
	localparam logic [1:0] CFG_CHIP_BYTES = 2'd2;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
	} region_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic shl;
	} cell_ctrl_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] gap;
		logic [31:0] next_end;
		logic        tail_ok;
		logic [31:0] tail_off;
		logic [31:0] tail_gap;
	} scan_res_t;

endpackage

// ===== rtl/core/ffg_cell.sv =====
// ffg_cell: one slot of the sorted region chain
// does sorted insert from the broadcast region and shifts toward the head during a scan
// depends on ffg_pkg
module ffg_cell
	import ffg_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  region_t    new_rgn,
	input  logic       prev_gt,
	input  region_t    prev_rgn,
	input  region_t    next_rgn,
	output region_t    rgn,
	output logic       gt
);

	region_t rgn_q;

	// equal starts stay ahead of the new region
	assign gt  = occ && (rgn_q.start > new_rgn.start);
	assign rgn = rgn_q;

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			rgn_q <= next_rgn;
		end else if (ctrl.ins) begin
			if (prev_gt) begin
				rgn_q <= prev_rgn;
			end else if (!occ || gt) begin
				rgn_q <= new_rgn;
			end
		end
	end

endmodule

// ===== rtl/core/ffg_scan.sv =====
// ffg_scan: gap checks for one scan step
// tests the head region against the running end and evaluates the tail gap
// depends on ffg_pkg
module ffg_scan
	import ffg_pkg::*;
(
	input  region_t     head,
	input  logic [31:0] end_val,
	input  logic [31:0] min_gap,
	input  logic [31:0] base_addr,
	input  logic [31:0] chip_bytes,
	output scan_res_t   res
);

	logic [31:0] tail_end;

	always_comb begin
		res.gap      = head.start - end_val;
		res.hit      = (head.start > base_addr) && (head.start > end_val) &&
		               (res.gap >= min_gap);
		res.next_end = head.start + head.length;

		tail_end     = (end_val < base_addr) ? base_addr : end_val;
		res.tail_off = tail_end;
		res.tail_gap = chip_bytes - tail_end;
		res.tail_ok  = (tail_end <= chip_bytes) && (res.tail_gap >= min_gap);
	end

endmodule

// ===== rtl/core/flash_free_gap_finder.sv =====
// flash_free_gap_finder: first-fit free gap search over occupied flash regions
// top level: config registers, sorted cell chain, scan sequencer and result register
// depends on ffg_pkg, ffg_cell, ffg_scan
//
//   channel   signals                                          direction
//   config    cfg_we, cfg_index, cfg_data                      in
//   request   in_valid/in_stall, region_start, region_length,  in
//             on_target_chip, last_entry
//   result    out_valid/out_stall, status, gap_offset,         out
//             gap_size
//
// a request is taken when in_stall is low; the chain inserts it in sorted place
// a request with last_entry starts a scan of each stored region until a gap fits,
// then of the tail gap; in_stall is high meanwhile
// the scan shifts the chain toward its head cell, which feeds the gap check
// the scan steps only while the result register is empty or being taken
// reset clears the region count and the control state; cell contents need no reset
module flash_free_gap_finder
	import ffg_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] region_start,
	input  logic [31:0] region_length,
	input  logic        on_target_chip,
	input  logic        last_entry,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] gap_offset,
	output logic [31:0] gap_size
);

	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_REGIONS);

	logic [31:0] min_gap_q;
	logic [31:0] base_addr_q;
	logic [31:0] chip_bytes_q;

	state_t      state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [31:0] end_q, end_d;

	logic        res_valid_q;
	status_t     res_status_q;
	logic [31:0] res_off_q;
	logic [31:0] res_size_q;

	logic        res_load;
	status_t     res_status_d;
	logic [31:0] res_off_d;
	logic [31:0] res_size_d;

	logic        in_acc;
	logic        out_free;
	cell_ctrl_t  ctrl;
	region_t     new_rgn;
	scan_res_t   scan;

	region_t     cell_rgn [MAX_REGIONS];
	logic        cell_gt  [MAX_REGIONS];

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !res_valid_q || !out_stall;

	assign new_rgn.start  = region_start;
	assign new_rgn.length = region_length;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q    <= '0;
			base_addr_q  <= '0;
			chip_bytes_q <= CHIP_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_GAP:    min_gap_q    <= cfg_data;
				CFG_BASE_ADDR:  base_addr_q  <= cfg_data;
				CFG_CHIP_BYTES: chip_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sorted region chain
	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		logic    occ;
		logic    prev_gt;
		region_t prev_rgn;
		region_t next_rgn;

		assign occ = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign prev_gt  = 1'b0;
			assign prev_rgn = new_rgn;
		end else begin : g_body
			assign prev_gt  = cell_gt[i-1];
			assign prev_rgn = cell_rgn[i-1];
		end

		if (i == MAX_REGIONS - 1) begin : g_tail
			assign next_rgn = cell_rgn[i];
		end else begin : g_link
			assign next_rgn = cell_rgn[i+1];
		end

		ffg_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (occ),
			.new_rgn  (new_rgn),
			.prev_gt  (prev_gt),
			.prev_rgn (prev_rgn),
			.next_rgn (next_rgn),
			.rgn      (cell_rgn[i]),
			.gt       (cell_gt[i])
		);
	end

	ffg_scan u_scan (
		.head       (cell_rgn[0]),
		.end_val    (end_q),
		.min_gap    (min_gap_q),
		.base_addr  (base_addr_q),
		.chip_bytes (chip_bytes_q),
		.res        (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			end_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			end_q   <= end_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		end_d        = end_q;
		ctrl         = '0;
		res_load     = 1'b0;
		res_status_d = ST_NOT_FOUND;
		res_off_d    = '0;
		res_size_d   = '0;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					// a full store drops the region
					if (on_target_chip && (count_q != FULL)) begin
						ctrl.ins = 1'b1;
						count_d  = count_q + CW'(1);
					end
					if (last_entry) begin
						end_d   = base_addr_q;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (out_free) begin
					if (min_gap_q == '0) begin
						res_load     = 1'b1;
						res_status_d = ST_INVALID;
						count_d      = '0;
						state_d      = S_IDLE;
					end else if (count_q == '0) begin
						res_load = 1'b1;
						if (scan.tail_ok) begin
							res_status_d = ST_FOUND;
							res_off_d    = scan.tail_off;
							res_size_d   = scan.tail_gap;
						end
						state_d = S_IDLE;
					end else if (scan.hit) begin
						res_load     = 1'b1;
						res_status_d = ST_FOUND;
						res_off_d    = end_q;
						res_size_d   = scan.gap;
						count_d      = '0;
						state_d      = S_IDLE;
					end else begin
						ctrl.shl = 1'b1;
						count_d  = count_q - CW'(1);
						end_d    = scan.next_end;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status_d;
			res_off_q    <= res_off_d;
			res_size_q   <= res_size_d;
		end
	end

	assign out_valid  = res_valid_q;
	assign status     = res_status_q;
	assign gap_offset = res_off_q;
	assign gap_size   = res_size_q;

endmodule

// ===== tb/flash_free_gap_finder_test.sv =====
// flash_free_gap_finder_test: self-checking bench for the first-fit free gap finder
// region requests flow from a queue-fed driver; a scoreboard predicts each gap search result
// depends on ffg_pkg and flash_free_gap_finder
module flash_free_gap_finder_test import ffg_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REGIONS = MAX_REGIONS_DEF;
	localparam int SETTLE_CYCLES = MAX_REGIONS + 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int N_PHASES = 12;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
		logic        on_chip;
		logic        last;
	} region_req_t;

	typedef struct packed {
		status_t     st;
		logic [31:0] gap_off;
		logic [31:0] gap_len;
	} gap_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_MIN_GAP;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] region_start = '0;
	logic [31:0] region_length = '0;
	logic        on_target_chip = 1'b0;
	logic        last_entry = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] gap_offset;
	logic [31:0] gap_size;

	// predictor state: configuration copy and the sorted region list
	logic [31:0] req_size = '0;
	logic [31:0] min_offset = '0;
	logic [31:0] flash_bytes = CHIP_BYTES_RST;
	logic [31:0] stored_start [MAX_REGIONS];
	logic [31:0] stored_len [MAX_REGIONS];
	int          stored_cnt = 0;

	region_req_t region_reqs [$];
	gap_result_t expected_gaps [$];
	int          reqs_queued = 0;
	int          reqs_taken = 0;
	int          errors = 0;
	int          quiet_cycles = 0;
	int          snd_idle_pct = 0;
	int          rcv_idle_pct = 0;
	int          rx_hold_reqs = 0;
	int          rx_hold_served = 0;
	int          rx_hold_left = 0;

	flash_free_gap_finder #(.MAX_REGIONS(MAX_REGIONS)) i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sorted insert; equal starts go behind the ones already stored
	function automatic void store_region(logic [31:0] s, logic [31:0] len);
		int pos;
		if (stored_cnt >= MAX_REGIONS)
			return;
		pos = 0;
		while (pos < stored_cnt && stored_start[pos] <= s)
			pos++;
		for (int k = stored_cnt; k > pos; k--) begin
			stored_start[k] = stored_start[k - 1];
			stored_len[k] = stored_len[k - 1];
		end
		stored_start[pos] = s;
		stored_len[pos] = len;
		stored_cnt++;
	endfunction

	function automatic gap_result_t first_fit_search();
		gap_result_t r;
		logic [31:0] run_end;
		logic [31:0] gap;
		r.st = ST_NOT_FOUND;
		r.gap_off = '0;
		r.gap_len = '0;
		run_end = min_offset;
		if (req_size == 32'd0) begin
			r.st = ST_INVALID;
			return r;
		end
		for (int i = 0; i < stored_cnt; i++) begin
			if (stored_start[i] > min_offset && stored_start[i] > run_end) begin
				gap = stored_start[i] - run_end;
				if (gap >= req_size) begin
					r.st = ST_FOUND;
					r.gap_off = run_end;
					r.gap_len = gap;
					return r;
				end
			end
			run_end = stored_start[i] + stored_len[i];
		end
		if (run_end < min_offset)
			run_end = min_offset;
		// tail gap only exists when the running end is still inside the flash
		if (run_end <= flash_bytes) begin
			gap = flash_bytes - run_end;
			if (gap >= req_size) begin
				r.st = ST_FOUND;
				r.gap_off = run_end;
				r.gap_len = gap;
			end
		end
		return r;
	endfunction

	// called right after a rising edge; the write lands on the next one
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_MIN_GAP:    req_size = val;
			CFG_BASE_ADDR:  min_offset = val;
			CFG_CHIP_BYTES: flash_bytes = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] rs, input logic [31:0] so,
			input logic [31:0] fs, input bit poke_unused);
		@(posedge clk);
		write_reg(CFG_MIN_GAP, rs);
		write_reg(CFG_BASE_ADDR, so);
		write_reg(CFG_CHIP_BYTES, fs);
		if (poke_unused)
			write_reg(CFG_UNUSED, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic push_req(input logic [31:0] s, input logic [31:0] len,
			input logic on_chip, input logic last);
		region_req_t r;
		r.start = s;
		r.len = len;
		r.on_chip = on_chip;
		r.last = last;
		region_reqs.push_back(r);
		reqs_queued++;
	endtask

	task automatic wait_drained();
		while (reqs_taken != reqs_queued || expected_gaps.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one region list of n requests, the last one triggering the search
	task automatic queue_random_query(input int n);
		logic [31:0] hi;
		logic [31:0] len_hi;
		logic [31:0] s;
		logic [31:0] len;
		logic [31:0] prev_s;
		int r;
		prev_s = min_offset;
		hi = (flash_bytes > 32'hE000_0000) ? 32'hFFFF_FFFF :
			flash_bytes + (flash_bytes >> 3) + 32'h100;
		len_hi = (flash_bytes >> 3) + 32'h40;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 10) begin
				s = $urandom;
				len = $urandom;
			end else if (r < 20) begin
				s = prev_s;
				len = $urandom_range(len_hi, 0);
			end else if (r < 30) begin
				s = min_offset + $urandom_range(32'h40, 0);
				len = $urandom_range(32'h80, 0);
			end else begin
				s = $urandom_range(hi, 0);
				len = $urandom_range(len_hi, 0);
			end
			push_req(s, len, $urandom_range(99) < 85, k == n - 1);
			prev_s = s;
		end
	endtask

	always @(posedge clk) begin : request_driver
		region_req_t nxt;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (region_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				nxt = region_reqs.pop_front();
				in_valid <= 1'b1;
				region_start <= nxt.start;
				region_length <= nxt.len;
				on_target_chip <= nxt.on_chip;
				last_entry <= nxt.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_receiver
		if (rx_hold_served != rx_hold_reqs) begin
			rx_hold_served = rx_hold_reqs;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin : scoreboard
		gap_result_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (expected_gaps.size() == 0) begin
					errors++;
					$display("%0t unexpected result: status %0d offset %h size %h",
						$time, status, gap_offset, gap_size);
				end else begin
					want = expected_gaps.pop_front();
					if (status !== want.st || gap_offset !== want.gap_off ||
							gap_size !== want.gap_len) begin
						errors++;
						$display("%0t mismatch: expected status %0d offset %h size %h",
							$time, want.st, want.gap_off, want.gap_len);
						$display("%0t           actual status %0d offset %h size %h",
							$time, status, gap_offset, gap_size);
					end
				end
			end
			// predict after the compare so a new expectation never meets an older result
			if (in_valid && !in_stall) begin
				quiet_cycles = 0;
				reqs_taken++;
				if (on_target_chip)
					store_region(region_start, region_length);
				if (last_entry) begin
					expected_gaps.push_back(first_fit_search());
					stored_cnt = 0;
				end
			end
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("flash_free_gap_finder regression: fail");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] f;
		logic [31:0] o;
		logic [31:0] rq;
		int budget;
		int n;
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config has zero required size: invalid argument
		push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		settle();
		set_config(32'd16, 32'h100, 32'h1_0000, 1'b0);
		// unsorted arrival, equal starts, an off-chip request, gap before the first region
		push_req(32'h800, 32'h100, 1'b1, 1'b0);
		push_req(32'h400, 32'h100, 1'b1, 1'b0);
		push_req(32'h400, 32'h10, 1'b1, 1'b0);
		push_req(32'h9000, 32'h40, 1'b0, 1'b0);
		push_req(32'h200, 32'h50, 1'b1, 1'b1);
		// off-chip last request on an empty list: tail gap from the offset
		push_req(32'h100, 32'h20, 1'b0, 1'b1);
		// region runs past the flash size: the gap before it is found
		push_req(32'hFFF0, 32'h100, 1'b1, 1'b1);
		// end address wraps around zero
		push_req(32'hFFFF_FF00, 32'h200, 1'b1, 1'b1);
		push_req(32'h0, 32'h0, 1'b1, 1'b0);
		push_req(32'h50, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// gap too small and tail past the flash: nothing fits
		push_req(32'h108, 32'hFF00, 1'b1, 1'b1);
		settle();
		set_config(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
		push_req(32'h0, 32'h0, 1'b0, 1'b1);
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			snd_idle_pct = (p < 4) ? 19 : (p < 8) ? 46 : 0;
			rcv_idle_pct = (p < 4) ? 46 : (p < 8) ? 19 : 0;
			case (p)
				0: set_config(32'd1, 32'h0, 32'h0, 1'b0);
				1: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
				2: set_config(32'h0, $urandom, $urandom_range(32'h10_0000, 32'h1000), 1'b0);
				default: begin
					f = $urandom_range(32'h10_0000, 32'h1000);
					o = ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(f >> 1, 0);
					rq = $urandom_range(f >> 4, 1);
					set_config(rq, o, f, p == 6);
				end
			endcase
			budget = (p < 3) ? 25 : 50;
			// once queue a list of more requests than the region store holds
			if (p == 4)
				queue_random_query(36);
			// long receiver hold so the result side backs up into the request side
			if (p == 5)
				rx_hold_reqs++;
			// two halves; the sender pauses in between until all results are in
			for (int h = 0; h < 2; h++) begin
				n = 0;
				while (n < budget / 2) begin
					len = $urandom_range(99);
					len = (len < 80) ? $urandom_range(6, 1) :
						(len < 95) ? $urandom_range(20, 7) : $urandom_range(40, 30);
					queue_random_query(len);
					n += len;
				end
				wait_drained();
			end
			settle();
		end

		settle();
		if (errors == 0)
			$display("flash_free_gap_finder regression: pass");
		else
			$display("flash_free_gap_finder regression: fail");
		$finish;
	end

endmodule
